### rtl/lksl_pkg.sv
// Shared constants and types for the lane keeping steering law.
// Holds angle constants, the CORDIC arctangent table and register indexes.
`timescale 1ns / 1ps
package lksl_pkg;
    localparam int CordicStepsDefault = 16;
    localparam int AtanEntries = 24;
    localparam logic signed [17:0] Ang2Pi = 18'sd25736;
    localparam logic signed [17:0] AngPi = 18'sd12868;
    localparam logic signed [17:0] AngHalfPi = 18'sd6434;
    localparam logic signed [31:0] CordicKQ30 = 32'sd652032874;
    localparam logic [15:0] GainReset = 16'd6554;
    localparam logic [14:0] LimitReset = 15'd3277;
    localparam logic [0:0] RegGain = 1'b0;
    localparam logic [0:0] RegLimit = 1'b1;

    function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
        case (i)
            5'd0: atan_q24 = 32'sd13176795;
            5'd1: atan_q24 = 32'sd7778716;
            5'd2: atan_q24 = 32'sd4110060;
            5'd3: atan_q24 = 32'sd2086331;
            5'd4: atan_q24 = 32'sd1047214;
            5'd5: atan_q24 = 32'sd524117;
            5'd6: atan_q24 = 32'sd262123;
            5'd7: atan_q24 = 32'sd131069;
            5'd8: atan_q24 = 32'sd65536;
            5'd9: atan_q24 = 32'sd32768;
            5'd10: atan_q24 = 32'sd16384;
            5'd11: atan_q24 = 32'sd8192;
            5'd12: atan_q24 = 32'sd4096;
            5'd13: atan_q24 = 32'sd2048;
            5'd14: atan_q24 = 32'sd1024;
            5'd15: atan_q24 = 32'sd512;
            5'd16: atan_q24 = 32'sd256;
            5'd17: atan_q24 = 32'sd128;
            5'd18: atan_q24 = 32'sd64;
            5'd19: atan_q24 = 32'sd32;
            5'd20: atan_q24 = 32'sd16;
            5'd21: atan_q24 = 32'sd8;
            5'd22: atan_q24 = 32'sd4;
            5'd23: atan_q24 = 32'sd2;
            default: atan_q24 = 32'sd0;
        endcase
    endfunction

    // Heading into 0..2pi; inputs span less than two turns on each side.
    function automatic logic signed [17:0] wrap_heading(input logic signed [15:0] h);
        logic signed [17:0] t;
        t = 18'(h);
        if (t < 0) t = t + Ang2Pi;
        if (t < 0) t = t + Ang2Pi;
        if (t > Ang2Pi) t = t - Ang2Pi;
        wrap_heading = t;
    endfunction
endpackage

### rtl/lane_keeping_steering_law.sv
// Top level of the lane keeping steering law.
// Uses lksl_pkg and lksl_cordic.
//
// One word is taken when start is high and busy is low; busy then stays high
// until the result. The heading term is formed in S_ERR and S_REV while the
// CORDIC unit, started from S_ERR, forms sine and cosine of the car heading.
// A single 32x32 multiplier then forms four products, one per cycle,
// accumulated into the lateral sum, and a final multiply applies the gain.
// Busy falls together with the rise of done, so the next word can be accepted
// at the edge that ends the done cycle; no new word is taken before that.
// steer_angle is valid in the single cycle that done is high; the receiver
// cannot stall. Configuration writes are always ready; a write while busy can
// still change the gain or limit used for the word in flight. Reset clears
// the sequencer and restores register defaults.
`timescale 1ns / 1ps
module lane_keeping_steering_law #(
    parameter int CORDIC_STEPS = lksl_pkg::CordicStepsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [19:0] car_x,
    input  logic signed [19:0] car_y,
    input  logic signed [15:0] car_heading,
    input  logic signed [19:0] near_x,
    input  logic signed [19:0] near_y,
    input  logic signed [15:0] near_heading,
    input  logic signed [19:0] next_x,
    input  logic signed [19:0] next_y,
    input  logic signed [15:0] next_heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] steer_angle
);
    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_REV, S_CORD, S_P0, S_P1, S_P2, S_P3, S_MAG, S_GAIN, S_OUT
    } state_t;

    state_t             state_reg;
    logic [15:0]        gain_reg;
    logic [14:0]        limit_reg;
    logic signed [17:0] ch_reg, ah_reg, bh_reg;
    logic signed [20:0] d_reg [4];
    logic signed [17:0] err_reg;
    logic signed [55:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [25:0]        m_reg;
    logic               pos_reg;
    logic               cord_go, cord_done;
    logic signed [31:0] co, si;
    logic signed [17:0] he, rev;
    logic signed [31:0] ma, mb;
    logic signed [63:0] mul;
    logic signed [16:0] adj, tot_s;
    logic signed [18:0] total;
    logic [41:0]        gm;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    function automatic logic signed [17:0] herr(input logic signed [17:0] c,
        input logic signed [17:0] a, input logic signed [17:0] b);
        logic signed [18:0] m, d, e;
        m = (19'(a) + 19'(b)) >>> 1;
        d = 19'(a) - 19'(b);
        if (d > 19'(lksl_pkg::AngPi) || d < -19'(lksl_pkg::AngPi)) m = 19'(a);
        e = m - 19'(c);
        if (e < 19'(lksl_pkg::AngPi) && e > -19'(lksl_pkg::AngPi)) herr = 18'(e);
        else if (19'(c) < m) herr = 18'(e - 19'(lksl_pkg::Ang2Pi));
        else herr = 18'(e + 19'(lksl_pkg::Ang2Pi));
    endfunction

    lksl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .go(cord_go), .heading(ch_reg),
        .done(cord_done), .cosine(co), .sine(si)
    );

    always_comb
    begin
        rev = ch_reg + lksl_pkg::AngPi;
        if (rev > lksl_pkg::Ang2Pi) rev = rev - lksl_pkg::Ang2Pi;
        he = herr((state_reg == S_ERR) ? ch_reg : rev, ah_reg, bh_reg);
        cord_go = (state_reg == S_ERR);
        ma = 32'(d_reg[0]);
        mb = si;
        case (state_reg)
            S_P1: begin ma = 32'(d_reg[1]); mb = co; end
            S_P2: begin ma = 32'(d_reg[2]); mb = si; end
            S_P3: begin ma = 32'(d_reg[3]); mb = co; end
            S_GAIN: begin ma = 32'(m_reg); mb = 32'(gain_reg); end
            default: begin ma = 32'(d_reg[0]); mb = si; end
        endcase
        mul = 64'(ma) * 64'(mb);
        gm = 42'(prod_reg) >> 11;
        adj = (gm > 42'(limit_reg)) ? 17'(limit_reg) : 17'(gm);
        if (pos_reg) adj = -adj;
        total = 19'(err_reg) + 19'(adj);
        if (total > 19'sd32767) tot_s = 17'sd32767;
        else if (total < -19'sd32768) tot_s = -17'sd32768;
        else tot_s = 17'(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gain_reg <= lksl_pkg::GainReset;
            limit_reg <= lksl_pkg::LimitReset;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == lksl_pkg::RegGain) gain_reg <= cfg_data;
                else limit_reg <= cfg_data[14:0];
            end
            case (state_reg)
                S_IDLE: if (start) state_reg <= S_ERR;
                S_ERR:  state_reg <= S_REV;
                S_REV:  state_reg <= S_CORD;
                S_CORD: if (cord_done) state_reg <= S_P0;
                S_P0:   state_reg <= S_P1;
                S_P1:   state_reg <= S_P2;
                S_P2:   state_reg <= S_P3;
                S_P3:   state_reg <= S_MAG;
                S_MAG:  state_reg <= S_GAIN;
                S_GAIN: state_reg <= S_OUT;
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                    done <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers; each product is registered and folded in next cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ch_reg <= lksl_pkg::wrap_heading(car_heading);
                ah_reg <= lksl_pkg::wrap_heading(near_heading);
                bh_reg <= lksl_pkg::wrap_heading(next_heading);
                d_reg[0] <= 21'(near_x) - 21'(car_x);
                d_reg[1] <= 21'(near_y) - 21'(car_y);
                d_reg[2] <= 21'(next_x) - 21'(car_x);
                d_reg[3] <= 21'(next_y) - 21'(car_y);
            end
            S_ERR: err_reg <= he;
            S_REV:
            begin
                if ((he < 0 ? -he : he) < (err_reg < 0 ? -err_reg : err_reg))
                    err_reg <= he;
                acc_reg <= '0;
            end
            S_P0: prod_reg <= mul;
            S_P1:
            begin
                acc_reg <= acc_reg + 56'(prod_reg);
                prod_reg <= mul;
            end
            S_P2:
            begin
                acc_reg <= acc_reg - 56'(prod_reg);
                prod_reg <= mul;
            end
            S_P3:
            begin
                acc_reg <= acc_reg + 56'(prod_reg);
                prod_reg <= mul;
            end
            S_MAG:
            begin
                m_reg <= (acc_reg - 56'(prod_reg) < 0)
                    ? 26'((56'sd0 - (acc_reg - 56'(prod_reg))) >>> 30)
                    : 26'((acc_reg - 56'(prod_reg)) >>> 30);
                pos_reg <= (acc_reg - 56'(prod_reg)) > 0;
            end
            S_GAIN: prod_reg <= mul;
            S_OUT: steer_angle <= 16'(tot_s);
            default: ;
        endcase
    end
endmodule

### rtl/lksl_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a heading in Q30.
// One micro-rotation per cycle; depends on lksl_pkg.
`timescale 1ns / 1ps
module lksl_cordic #(
    parameter int CORDIC_STEPS = lksl_pkg::CordicStepsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [17:0]  heading,
    output logic                done,
    output logic signed [31:0]  cosine,
    output logic signed [31:0]  sine
);
    localparam int IW = $clog2(CORDIC_STEPS + 1);

    logic               run_reg;
    logic [IW-1:0]      step_reg;
    logic               neg_reg;
    logic signed [32:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic signed [17:0] t0, t1;
    logic               neg0;
    logic signed [32:0] xs, ys;
    logic signed [31:0] at;

    always_comb
    begin
        t0 = heading;
        neg0 = 1'b0;
        if (t0 > lksl_pkg::AngPi) t0 = t0 - lksl_pkg::Ang2Pi;
        t1 = t0;
        if (t0 > lksl_pkg::AngHalfPi)
        begin
            t1 = t0 - lksl_pkg::AngPi;
            neg0 = 1'b1;
        end
        else if (t0 < -lksl_pkg::AngHalfPi)
        begin
            t1 = t0 + lksl_pkg::AngPi;
            neg0 = 1'b1;
        end
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = lksl_pkg::atan_q24(5'(step_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            step_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == IW'(CORDIC_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    done <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg <= 33'(lksl_pkg::CordicKQ30);
            y_reg <= '0;
            z_reg <= 32'(t1) <<< 12;
            neg_reg <= neg0;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cosine = neg_reg ? 32'(-x_reg) : 32'(x_reg);
    assign sine   = neg_reg ? 32'(-y_reg) : 32'(y_reg);
endmodule

### rtl/lksl_checker.sv
// Port-level checks for the lane keeping steering law.
// Bound to lane_keeping_steering_law; uses no package.
`timescale 1ns / 1ps
module lksl_port_checks (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while still busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy dropped without result");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready) else $error("config port not ready");
endmodule

bind lane_keeping_steering_law lksl_port_checks u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .cfg_ready(cfg_ready)
);
